/* sv/assert_macros.svh */
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define RWAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rwac checker: same-cycle property failed");

// Condition implies consequence in the next cycle.
`define RWAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rwac checker: next-cycle property failed");

`endif

/* sv/rwac_pkg.sv */
// Types and constants shared by the ring window average and calibration block.
`timescale 1ns / 1ps

package rwac_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int VALUE_W   = 24;
    localparam int CH_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int LEVEL_W   = 4;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 64;
    localparam int X_W       = 16;
    localparam int DIV_W     = 48;
    localparam int DIV_CNT_W = 6;
    localparam int FRAC_BITS = 16;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [CH_W-1:0] CH_TEMP     = 2'd0;
    localparam logic [CH_W-1:0] CH_HUM      = 2'd1;
    localparam logic [CH_W-1:0] CH_HUM_TEMP = 2'd2;
    localparam logic [CH_W-1:0] CH_UNUSED   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_OFF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_GAIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_SQ    = 3'd6;

    localparam logic signed [SAMPLE_W-1:0] TEMP_LOW  = -16'sd4000;
    localparam logic signed [SAMPLE_W-1:0] TEMP_HIGH = 16'sd12500;
    localparam logic signed [SAMPLE_W-1:0] HUM_LOW   = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] HUM_HIGH  = 16'sd10000;

    localparam logic signed [COEF_W-1:0] GAIN_RESET    = 32'sd65536;
    localparam logic signed [COEF_W-1:0] CAL_X_SCALE   = 32'sd100;
    localparam logic signed [COEF_W-1:0] CAL_OFF_SCALE = 32'sd10000;

    // Division by 100 is a multiplication by ceil(2^37 / 100) and a shift by 37.
    // Larger magnitudes saturate anyway, so clamping them keeps the quotient exact.
    localparam logic signed [COEF_W-1:0] CAL_RECIP       = 32'sd1374389535;
    localparam int                       CAL_RECIP_SHIFT = 37;
    localparam logic [DIV_W-1:0]         CAL_Y_CLAMP     = 48'd838860899;

    localparam logic [DIV_W-1:0] SAT_POS_MAG = 48'd8388607;
    localparam logic [DIV_W-1:0] SAT_NEG_MAG = 48'd8388608;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 24'sd8388607;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = -24'sd8388608;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] temp_sample;
        logic signed [SAMPLE_W-1:0] hum_sample;
        logic signed [SAMPLE_W-1:0] hum_temp_sample;
        logic [CH_W-1:0]            channel;
    } t_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [CH_W-1:0]           out_channel;
        logic                      no_data;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_MDIV,
        S_MEAN,
        S_MUL,
        S_CLOAD,
        S_CMUL,
        S_SAT,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_XX,
        MS_X100,
        MS_SQ,
        MS_GAIN,
        MS_OFF,
        MS_LAST
    } t_mul_step;

endpackage

/* sv/rwac_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module rwac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/ring_window_average_calibrate.sv */
// Top level of the ring window average with quadratic calibration.
`timescale 1ns / 1ps

// A store item is taken and busy stays low, so another item may follow at
// once. A read keeps busy high through its result; it sums n samples,
// where n is the window length (1 at level 0, else level times WINDOW_STEP,
// clamped to the stored samples), and the sum has SW = 16 + clog2(RING_DEPTH)
// bits, 21 at the default depth. Channel 2 skips calibration, and a read
// with no data goes straight to the result. The ring RAM delivers one sample
// per cycle, a serial divider forms the mean's SW bits, and one shared 32 by
// 32 multiplier computes the polynomial in six steps and then scales it down in
// one more step by a reciprocal multiplication. The result is shown for exactly
// one cycle with o_res_valid and must be taken then, since the receiver cannot
// stall the block. Configuration writes are always accepted and should only be
// issued while busy is low.
module ring_window_average_calibrate #(
    parameter int RING_DEPTH  = 32,
    parameter int WINDOW_STEP = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rwac_pkg::t_item                    i_item,
    output logic                               o_res_valid,
    output rwac_pkg::t_result                  o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rwac_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rwac_pkg::CFG_W-1:0]         i_cfg_data
);

    import rwac_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int PW    = $clog2(RING_DEPTH + 1);
    localparam int NW    = (PW > 8) ? PW : 8;
    localparam int SW    = SAMPLE_W + $clog2(RING_DEPTH);
    localparam int RAM_W = 3 * SAMPLE_W;

    localparam logic [PW-1:0]        DEPTH_P   = PW'(RING_DEPTH);
    localparam logic [NW-1:0]        DEPTH_N   = NW'(RING_DEPTH);
    localparam logic [NW-1:0]        STEP_N    = NW'(WINDOW_STEP);
    localparam logic [AW-1:0]        LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [DIV_CNT_W-1:0] MEAN_ITER = DIV_CNT_W'(SW);

    t_state    r_state, n_state;
    t_mul_step r_step, n_step;

    logic [LEVEL_W-1:0]       r_level;
    logic signed [COEF_W-1:0] r_temp_off, r_temp_gain, r_temp_sq;
    logic signed [COEF_W-1:0] r_hum_off, r_hum_gain, r_hum_sq;
    logic [PW-1:0]            r_wp;
    logic                     r_wrapped;

    logic [CH_W-1:0]          r_ch;
    logic [NW-1:0]            r_rd_left;
    logic [NW-1:0]            r_count;
    logic [AW-1:0]            r_rd_addr;
    logic                     r_rd_vld;
    logic signed [SW-1:0]     r_sum;
    logic [DIV_W-1:0]         r_dq;
    logic [NW-1:0]            r_rem;
    logic [NW-1:0]            r_dvs;
    logic [DIV_CNT_W-1:0]     r_div_cnt;
    logic                     r_neg;
    logic signed [X_W-1:0]    r_x;
    logic signed [COEF_W-1:0] r_xx;
    logic signed [COEF_W-1:0] r_x100;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    t_result                  r_res;

    logic                     accept, store_acc, read_acc;
    logic                     sample_ok, wp_full, read_empty;
    logic [PW-1:0]            wp_base;
    logic                     ram_we, ram_re;
    logic [RAM_W-1:0]         ram_wdata, ram_rdata;
    logic [NW-1:0]            n_raw, wp_n, n_win;
    logic [NW:0]              start_ext;
    logic [AW-1:0]            win_start;
    logic signed [SAMPLE_W-1:0] rd_lane;
    logic                     sum_done;
    logic [SW-1:0]            sum_mag;
    logic [NW:0]              rem_sh, rem_sub;
    logic                     div_bit;
    logic [NW-1:0]            rem_next;
    logic [DIV_W-1:0]         dq_next;
    logic signed [X_W-1:0]    x_next;
    logic [PROD_W-1:0]        acc_mag;
    logic [DIV_W-1:0]         cal_y;
    logic [DIV_W-1:0]         cal_q;
    logic signed [VALUE_W-1:0] sat_value;
    logic signed [COEF_W-1:0] coef_off, coef_gain, coef_sq;
    logic signed [COEF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    assign accept    = start && !busy;
    assign store_acc = accept && (i_item.cmd == CMD_STORE);
    assign read_acc  = accept && (i_item.cmd == CMD_READ);

    assign sample_ok = (i_item.temp_sample >= TEMP_LOW) && (i_item.temp_sample <= TEMP_HIGH)
                    && (i_item.hum_temp_sample >= TEMP_LOW)
                    && (i_item.hum_temp_sample <= TEMP_HIGH)
                    && (i_item.hum_sample >= HUM_LOW) && (i_item.hum_sample <= HUM_HIGH);

    assign wp_full    = (r_wp >= DEPTH_P);
    assign wp_base    = wp_full ? '0 : r_wp;
    assign ram_we     = store_acc && sample_ok;
    assign ram_wdata  = {i_item.hum_temp_sample, i_item.hum_sample, i_item.temp_sample};
    assign read_empty = (r_wp == '0) || (i_item.channel == CH_UNUSED);

    assign n_raw = NW'(r_level) * STEP_N;
    assign wp_n  = NW'(r_wp);

    always_comb begin
        if (r_level == '0) begin
            n_win = NW'(1);
        end else if (r_wrapped) begin
            n_win = (n_raw > DEPTH_N) ? DEPTH_N : n_raw;
        end else begin
            n_win = (n_raw > wp_n) ? wp_n : n_raw;
        end
        if (n_win <= wp_n) begin
            start_ext = {1'b0, wp_n} - {1'b0, n_win};
        end else begin
            start_ext = {1'b0, wp_n} + {1'b0, DEPTH_N} - {1'b0, n_win};
        end
    end

    assign win_start = start_ext[AW-1:0];

    always_comb begin
        unique case (r_ch)
            CH_HUM:      rd_lane = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
            CH_HUM_TEMP: rd_lane = ram_rdata[3*SAMPLE_W-1:2*SAMPLE_W];
            default:     rd_lane = ram_rdata[SAMPLE_W-1:0];
        endcase
    end

    assign sum_done = (r_rd_left == '0) && !r_rd_vld;
    assign sum_mag  = r_sum[SW-1] ? (~r_sum + SW'(1)) : r_sum;

    assign rem_sh   = {r_rem, r_dq[DIV_W-1]};
    assign rem_sub  = rem_sh - {1'b0, r_dvs};
    assign div_bit  = (rem_sh >= {1'b0, r_dvs});
    assign rem_next = div_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
    assign dq_next  = {r_dq[DIV_W-2:0], div_bit};

    assign x_next  = r_neg ? (~r_dq[X_W-1:0] + X_W'(1)) : r_dq[X_W-1:0];
    assign acc_mag = r_acc[PROD_W-1] ? (~r_acc + PROD_W'(1)) : r_acc;

    assign cal_y = (acc_mag[PROD_W-1:FRAC_BITS] > CAL_Y_CLAMP) ? CAL_Y_CLAMP
                                                               : acc_mag[PROD_W-1:FRAC_BITS];
    assign cal_q = DIV_W'(r_prod[PROD_W-1:CAL_RECIP_SHIFT]);

    always_comb begin
        if (r_neg) begin
            sat_value = (cal_q > SAT_NEG_MAG) ? VALUE_MIN : (~cal_q[VALUE_W-1:0] + VALUE_W'(1));
        end else begin
            sat_value = (cal_q > SAT_POS_MAG) ? VALUE_MAX : cal_q[VALUE_W-1:0];
        end
    end

    assign coef_off  = (r_ch == CH_HUM) ? r_hum_off : r_temp_off;
    assign coef_gain = (r_ch == CH_HUM) ? r_hum_gain : r_temp_gain;
    assign coef_sq   = (r_ch == CH_HUM) ? r_hum_sq : r_temp_sq;

    always_comb begin
        if (r_state == S_CMUL) begin
            mul_a = r_dq[COEF_W-1:0];
            mul_b = CAL_RECIP;
        end else begin
            unique case (r_step)
                MS_XX: begin
                    mul_a = COEF_W'(r_x);
                    mul_b = COEF_W'(r_x);
                end
                MS_X100: begin
                    mul_a = COEF_W'(r_x);
                    mul_b = CAL_X_SCALE;
                end
                MS_SQ: begin
                    mul_a = coef_sq;
                    mul_b = r_xx;
                end
                MS_GAIN: begin
                    mul_a = coef_gain;
                    mul_b = r_x100;
                end
                MS_OFF: begin
                    mul_a = coef_off;
                    mul_b = CAL_OFF_SCALE;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    rwac_ram #(
        .WIDTH(RAM_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(wp_base[AW-1:0]),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_rd_addr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (read_acc) begin
                    n_state = read_empty ? S_DONE : S_SUM;
                end
            end
            S_SUM: begin
                if (sum_done) begin
                    n_state = S_MDIV;
                end
            end
            S_MDIV: begin
                if (r_div_cnt == DIV_CNT_W'(1)) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                n_state = (r_ch == CH_HUM_TEMP) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                if (r_step == MS_LAST) begin
                    n_state = S_CLOAD;
                end
            end
            S_CLOAD: begin
                n_state = S_CMUL;
            end
            S_CMUL: begin
                n_state = S_SAT;
            end
            S_SAT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_step = MS_XX;
        if (r_state == S_MUL) begin
            unique case (r_step)
                MS_XX:   n_step = MS_X100;
                MS_X100: n_step = MS_SQ;
                MS_SQ:   n_step = MS_GAIN;
                MS_GAIN: n_step = MS_OFF;
                MS_OFF:  n_step = MS_LAST;
                default: n_step = MS_XX;
            endcase
        end
    end

    always_comb begin
        busy        = (r_state != S_IDLE);
        o_res_valid = (r_state == S_DONE);
        ram_re      = (r_state == S_SUM) && (r_rd_left != '0);
        o_cfg_ready = 1'b1;
        o_result    = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= MS_XX;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_level     <= '0;
            r_temp_off  <= '0;
            r_temp_gain <= GAIN_RESET;
            r_temp_sq   <= '0;
            r_hum_off   <= '0;
            r_hum_gain  <= GAIN_RESET;
            r_hum_sq    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (store_acc) begin
                if (wp_full) begin
                    r_wrapped <= 1'b1;
                end
                r_wp <= sample_ok ? (wp_base + PW'(1)) : wp_base;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LEVEL:     r_level     <= i_cfg_data[LEVEL_W-1:0];
                    CFG_TEMP_OFF:  r_temp_off  <= i_cfg_data;
                    CFG_TEMP_GAIN: r_temp_gain <= i_cfg_data;
                    CFG_TEMP_SQ:   r_temp_sq   <= i_cfg_data;
                    CFG_HUM_OFF:   r_hum_off   <= i_cfg_data;
                    CFG_HUM_GAIN:  r_hum_gain  <= i_cfg_data;
                    CFG_HUM_SQ:    r_hum_sq    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        unique case (r_state)
            S_IDLE: begin
                if (read_acc) begin
                    r_ch              <= i_item.channel;
                    r_rd_left         <= n_win;
                    r_count           <= n_win;
                    r_rd_addr         <= win_start;
                    r_rd_vld          <= 1'b0;
                    r_sum             <= '0;
                    r_res.value       <= '0;
                    r_res.out_channel <= i_item.channel;
                    r_res.no_data     <= read_empty;
                end
            end
            S_SUM: begin
                if (r_rd_left != '0) begin
                    r_rd_addr <= (r_rd_addr == LAST_ADDR) ? '0 : (r_rd_addr + AW'(1));
                    r_rd_left <= r_rd_left - NW'(1);
                    r_rd_vld  <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (r_rd_vld) begin
                    r_sum <= r_sum + SW'(rd_lane);
                end
                if (sum_done) begin
                    r_dq      <= {sum_mag, {(DIV_W - SW){1'b0}}};
                    r_rem     <= '0;
                    r_dvs     <= r_count;
                    r_div_cnt <= MEAN_ITER;
                    r_neg     <= r_sum[SW-1];
                end
            end
            S_MDIV: begin
                r_dq      <= dq_next;
                r_rem     <= rem_next;
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            S_MEAN: begin
                r_x         <= x_next;
                r_res.value <= VALUE_W'(x_next);
            end
            S_MUL: begin
                unique case (r_step)
                    MS_X100: r_xx   <= r_prod[COEF_W-1:0];
                    MS_SQ:   r_x100 <= r_prod[COEF_W-1:0];
                    MS_GAIN: r_acc  <= r_prod;
                    MS_OFF:  r_acc  <= r_acc + r_prod;
                    MS_LAST: r_acc  <= r_acc + r_prod;
                    default: begin
                    end
                endcase
            end
            S_CLOAD: begin
                r_dq  <= cal_y;
                r_neg <= r_acc[PROD_W-1];
            end
            S_SAT: begin
                r_res.value <= sat_value;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/rwac_checker.sv */
// Port-level assertions for the ring window average block and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rwac_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input rwac_pkg::t_item   i_item,
    input logic              o_res_valid,
    input rwac_pkg::t_result o_result
);

    import rwac_pkg::*;

    `RWAC_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_res_valid, !o_res_valid)
    `RWAC_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, start && !busy && (i_item.cmd == CMD_READ), busy)
    `RWAC_ASSERT_NEXT(a_store_free, i_clk, i_rst_n, start && !busy && (i_item.cmd == CMD_STORE), !busy)
    `RWAC_ASSERT_SAME(a_nodata_zero, i_clk, i_rst_n, o_res_valid && o_result.no_data, o_result.value == '0)

endmodule

bind ring_window_average_calibrate rwac_checker u_rwac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_item     (i_item),
    .o_res_valid(o_res_valid),
    .o_result   (o_result)
);
